// ===== sv/assert_macros.svh =====
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every rising edge of clk outside reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Check that a condition at one edge implies a consequence at the next edge.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/urde_pkg.sv =====
package urde_pkg;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_RX    = 2'd2,
        OP_TICK  = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_COLLECT = 2'd1
    } phase_t;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_TIMEOUT = 2'd1;
    localparam logic [1:0] STATUS_CRC_ERR = 2'd2;

    localparam logic KIND_TX       = 1'b0;
    localparam logic KIND_COMPLETE = 1'b1;

    localparam logic [7:0]  SYNC_BYTE     = 8'h05;
    localparam logic [7:0]  REG_FLAG      = 8'h80;
    localparam logic [7:0]  CRC_POLY      = 8'h07;
    localparam logic [15:0] TIMEOUT_RESET = 16'd20;
    localparam logic [15:0] TICK_MAX      = 16'hFFFF;
    localparam logic [2:0]  LAST_INDEX    = 3'd7;
    localparam logic [2:0]  REPLY_FIRST   = 3'd3;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [7:0]  node_address;
        logic [6:0]  register_index;
        logic [31:0] write_value;
        logic [7:0]  rx_byte;
    } in_item_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  tx_byte;
        logic        last_byte;
        logic [1:0]  status;
        logic [31:0] read_value;
        logic        was_read;
    } out_item_t;

    // Reflected-input CRC-8: consume the data byte LSB first.
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in,
                                             input logic [7:0] data);
        logic [7:0] crc;
        logic [7:0] cur;
        logic       fb;
        crc = crc_in;
        cur = data;
        for (int b = 0; b < 8; b++)
        begin
            fb  = crc[7] ^ cur[0];
            crc = {crc[6:0], 1'b0};
            if (fb)
            begin
                crc = crc ^ CRC_POLY;
            end
            cur = {1'b0, cur[7:1]};
        end
        return crc;
    endfunction

endpackage

// ===== sv/uart_register_datagram_engine.sv =====
// Single-wire register datagram engine.
// Input channel (in_valid/in_ready/in_data) carries one item per transfer:
// a write or read command, a received line byte, or a time tick.
// Output channel (out_valid/out_ready/out_data) carries transmit bytes and
// transaction completions. A command taken while idle yields eight transmit
// bytes (sync, node, register, four data bytes, CRC-8); the eighth is marked
// by last_byte. The engine then collects eight reply bytes and issues one
// completion: ok, timeout or CRC mismatch, with the read value for reads.
// A result is held in the input register and then in the output register
// before it is offered. The input register takes one item per cycle while
// it is not held by a waiting result. Items that yield no result pass the
// input register even while a result waits; the output register holds a
// command until its eight transmit bytes have transferred and a completion
// until its single transfer. cfg_we/cfg_wdata write timeout_ticks (reset
// value 20); the user must write it only while idle, as the block does not.
// Reset clears the engine to idle, empties both registers and restores
// timeout_ticks. When the receiver stalls, hold the result and let the
// input register take one more item; then drop in_ready until space opens.

`include "assert_macros.svh"

module uart_register_datagram_engine (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  urde_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output urde_pkg::out_item_t out_data,
    input  logic                cfg_we,
    input  logic [15:0]         cfg_wdata
);

    // Configuration
    logic [15:0] timeout_reg;

    // Input register
    logic                s1_valid_reg;
    urde_pkg::in_item_t  s1_item_reg;

    // Transaction state
    urde_pkg::phase_t phase_reg, phase_next;
    logic             is_read_reg, is_read_next;
    logic [2:0]       rx_count_reg, rx_count_next;
    logic [15:0]      idle_ticks_reg, idle_ticks_next;
    logic [7:0]       crc_reg, crc_next;
    logic [31:0]      reply_reg, reply_next;

    // Result register
    logic        res_valid_reg;
    logic        res_tx_reg;
    logic [63:0] res_shift_reg;
    logic [2:0]  res_idx_reg;
    logic [1:0]  res_status_reg;
    logic [31:0] res_value_reg;
    logic        res_rd_reg;

    // Decode of the held item
    logic        busy;
    logic        is_cmd;
    logic        cmd_go;
    logic        rx_go;
    logic        rx_final;
    logic        tick_go;
    logic        tick_out;
    logic [15:0] ticks_inc;

    // Generated result
    logic        gen_tx;
    logic        gen_cmp;
    logic        gen_any;
    logic [63:0] gen_bytes;
    logic [1:0]  gen_status;
    logic [31:0] gen_value;

    // Flow control
    logic out_fire;
    logic res_done;
    logic slot_free;
    logic s1_adv;
    logic res_load;

    assign busy     = (phase_reg != urde_pkg::PH_IDLE);
    assign is_cmd   = (s1_item_reg.opcode == urde_pkg::OP_WRITE) ||
                      (s1_item_reg.opcode == urde_pkg::OP_READ);
    assign cmd_go   = is_cmd && !busy;
    assign rx_go    = (s1_item_reg.opcode == urde_pkg::OP_RX) && busy;
    assign rx_final = rx_go && (rx_count_reg == urde_pkg::LAST_INDEX);
    assign tick_go  = (s1_item_reg.opcode == urde_pkg::OP_TICK) && busy;
    assign ticks_inc = (idle_ticks_reg == urde_pkg::TICK_MAX) ? idle_ticks_reg
                                                               : idle_ticks_reg + 16'd1;
    assign tick_out = tick_go && (ticks_inc >= timeout_reg);

    assign gen_tx  = cmd_go;
    assign gen_cmp = rx_final || tick_out;
    assign gen_any = gen_tx || gen_cmp;

    // Advance the held item unless it has a result and the output is full.
    assign out_fire  = res_valid_reg && out_ready;
    assign res_done  = out_fire && (!res_tx_reg || (res_idx_reg == urde_pkg::LAST_INDEX));
    assign slot_free = !res_valid_reg || res_done;
    assign s1_adv    = s1_valid_reg && (!gen_any || slot_free);
    assign res_load  = s1_adv && gen_any;
    assign in_ready  = !s1_valid_reg || s1_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= urde_pkg::TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            timeout_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_item_reg <= in_data;
        end
    end

    // Next state of the transaction
    always_comb
    begin
        phase_next      = phase_reg;
        is_read_next    = is_read_reg;
        rx_count_next   = rx_count_reg;
        idle_ticks_next = idle_ticks_reg;
        crc_next        = crc_reg;
        reply_next      = reply_reg;
        if (cmd_go)
        begin
            phase_next      = urde_pkg::PH_COLLECT;
            is_read_next    = (s1_item_reg.opcode == urde_pkg::OP_READ);
            rx_count_next   = '0;
            idle_ticks_next = '0;
            crc_next        = '0;
            reply_next      = '0;
        end
        else if (gen_cmp)
        begin
            phase_next      = urde_pkg::PH_IDLE;
            rx_count_next   = '0;
            idle_ticks_next = '0;
        end
        else if (rx_go)
        begin
            idle_ticks_next = '0;
            crc_next        = urde_pkg::crc8_byte(crc_reg, s1_item_reg.rx_byte);
            rx_count_next   = rx_count_reg + 3'd1;
            if (rx_count_reg >= urde_pkg::REPLY_FIRST)
            begin
                reply_next = {reply_reg[23:0], s1_item_reg.rx_byte};
            end
        end
        else if (tick_go)
        begin
            idle_ticks_next = ticks_inc;
        end
    end

    // Result of the held item
    always_comb
    begin
        logic [31:0] data;
        logic [7:0]  crc;
        logic [7:0]  reg_byte;
        data      = (s1_item_reg.opcode == urde_pkg::OP_READ) ? 32'd0
                                                              : s1_item_reg.write_value;
        reg_byte  = urde_pkg::REG_FLAG | {1'b0, s1_item_reg.register_index};
        crc       = urde_pkg::crc8_byte(8'd0, urde_pkg::SYNC_BYTE);
        crc       = urde_pkg::crc8_byte(crc, s1_item_reg.node_address);
        crc       = urde_pkg::crc8_byte(crc, reg_byte);
        crc       = urde_pkg::crc8_byte(crc, data[31:24]);
        crc       = urde_pkg::crc8_byte(crc, data[23:16]);
        crc       = urde_pkg::crc8_byte(crc, data[15:8]);
        crc       = urde_pkg::crc8_byte(crc, data[7:0]);
        gen_bytes = {urde_pkg::SYNC_BYTE, s1_item_reg.node_address, reg_byte, data, crc};

        gen_status = urde_pkg::STATUS_OK;
        gen_value  = '0;
        if (tick_out)
        begin
            gen_status = urde_pkg::STATUS_TIMEOUT;
        end
        else if (is_read_reg)
        begin
            if (crc_reg == s1_item_reg.rx_byte)
            begin
                gen_value = reply_reg;
            end
            else
            begin
                gen_status = urde_pkg::STATUS_CRC_ERR;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= urde_pkg::PH_IDLE;
            is_read_reg    <= 1'b0;
            rx_count_reg   <= '0;
            idle_ticks_reg <= '0;
            crc_reg        <= '0;
            reply_reg      <= '0;
        end
        else if (s1_adv)
        begin
            phase_reg      <= phase_next;
            is_read_reg    <= is_read_next;
            rx_count_reg   <= rx_count_next;
            idle_ticks_reg <= idle_ticks_next;
            crc_reg        <= crc_next;
            reply_reg      <= reply_next;
        end
    end

    // Output register control: load a new result, step through a
    // transmit batch, or empty after its last transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
            res_tx_reg    <= 1'b0;
            res_idx_reg   <= '0;
        end
        else if (res_load)
        begin
            res_valid_reg <= 1'b1;
            res_tx_reg    <= gen_tx;
            res_idx_reg   <= '0;
        end
        else if (res_done)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (out_fire)
        begin
            res_idx_reg <= res_idx_reg + 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_shift_reg  <= gen_tx ? gen_bytes : 64'd0;
            res_status_reg <= gen_tx ? urde_pkg::STATUS_OK : gen_status;
            res_value_reg  <= gen_tx ? 32'd0 : gen_value;
            res_rd_reg     <= gen_tx ? 1'b0 : is_read_reg;
        end
        else if (out_fire)
        begin
            res_shift_reg <= {res_shift_reg[55:0], 8'd0};
        end
    end

    assign out_valid           = res_valid_reg;
    assign out_data.kind       = res_tx_reg ? urde_pkg::KIND_TX : urde_pkg::KIND_COMPLETE;
    assign out_data.tx_byte    = res_shift_reg[63:56];
    assign out_data.last_byte  = res_tx_reg && (res_idx_reg == urde_pkg::LAST_INDEX);
    assign out_data.status     = res_status_reg;
    assign out_data.read_value = res_value_reg;
    assign out_data.was_read   = res_rd_reg;

    `ASSERT_NEXT(a_batch_starts_sync, res_load && gen_tx,
        out_valid && (out_data.tx_byte == urde_pkg::SYNC_BYTE), "batch must open with sync")
    `ASSERT_NEXT(a_complete_goes_idle, res_load && gen_cmp,
        phase_reg == urde_pkg::PH_IDLE, "completion must return to idle")
    `ASSERT_ALWAYS(a_last_only_tx, !(out_valid && out_data.last_byte) ||
        (out_data.kind == urde_pkg::KIND_TX), "last_byte set on a completion")
    `ASSERT_ALWAYS(a_idle_counters_clear, busy || ((rx_count_reg == 3'd0) &&
        (idle_ticks_reg == 16'd0)), "counters not cleared while idle")

endmodule
